@@ rtl/wzl_pkg.sv @@
// Shared types and constants of the rolling-window z-score labeler.
`timescale 1ns / 1ps

package wzl_pkg;

    // Fixed field widths.
    localparam int PRICE_W = 32;
    localparam int THR_W   = 16;
    localparam int NORM_W  = 16;
    localparam int POS_W   = 6;
    localparam int QUO_W   = 32;
    localparam int ROOT_W  = 16;

    // Threshold after reset, Q0.16.
    localparam logic [THR_W-1:0] THR_RESET = 16'd131;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;       // write the input word into the ring
        logic rd;          // read the ring at the read pointer, then advance it
        logic p1_dat;      // first pass: add the price to the sum, square it
        logic p1_acc;      // first pass: add the square to the sum of squares
        logic k_clr;       // clear the position counter
        logic k_inc;       // advance the position counter
        logic ref_dat;     // reference price read: form the label, square the sum
        logic den;         // form the variance term and rewind the read pointer
        logic p2_dat;      // second pass: form the deviation magnitude
        logic div_start;   // start the divider
        logic sqrt_start;  // start the square root
        logic load_out;    // load the output word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full_next;   // the ring is full once this word is stored
        logic k_last;      // the position counter is at the last window slot
        logic flat;        // all window prices are equal
        logic div_done;    // divider finished
        logic sqrt_done;   // square root finished
    } t_stat;

endpackage

@@ rtl/window_zscore_labeler.sv @@
// Top level of the rolling-window z-score normalizer with up label.
`timescale 1ns / 1ps

// Each accepted price is stored in a ring of WINDOW+HORIZON+1 entries. While
// the ring is filling, no words are produced. Once it is full, every price
// releases WINDOW result words, oldest position first, the last one flagged
// by o_last; the input stays stalled until the last word of the sample has
// been taken. After its acceptance, a releasing price first runs the sum pass
// and the variance term; each result word then goes through the bit-serial
// divider (33 steps) and square root (16 steps), which run once per word
// unless all window prices are equal: then the value is zero and both are
// skipped. There is no clearing pass after reset: ring entries are never read
// before they are written. The threshold register may be written only while
// the block is idle.
module window_zscore_labeler #(
    parameter int WINDOW  = 64,
    parameter int HORIZON = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [wzl_pkg::PRICE_W-1:0]   i_close_price,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wzl_pkg::NORM_W-1:0]    o_norm_value,
    output logic [wzl_pkg::POS_W-1:0]     o_position,
    output logic                          o_up_label,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [wzl_pkg::THR_W-1:0]     i_cfg_wdata
);
    import wzl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    wzl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // Arithmetic and storage.
    wzl_dp #(
        .WINDOW  (WINDOW),
        .HORIZON (HORIZON)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_close_price (i_close_price),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_norm_value  (o_norm_value),
        .o_position    (o_position),
        .o_up_label    (o_up_label),
        .o_last        (o_last)
    );

endmodule

@@ rtl/wzl_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
`timescale 1ns / 1ps

module wzl_div #(
    parameter int DEN_W = 76
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DEN_W+23:0]           i_num,
    input  logic [DEN_W-1:0]            i_den,
    output logic                        o_done,
    output logic [wzl_pkg::QUO_W-1:0]   o_quo
);
    import wzl_pkg::*;

    localparam int NUM_W = DEN_W + 24;
    localparam int STEPS = QUO_W + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W:0]     r_rem;
    logic [STEPS-1:0]   r_low;
    logic [STEPS-1:0]   r_quo;
    logic               r_ovf;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W:0]     n_trial;
    logic               n_ge;

    // One trial subtraction per cycle.
    assign n_trial = {r_rem[DEN_W-1:0], r_low[STEPS-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (DEN_W+1)'(i_num >> STEPS);
            r_low <= i_num[STEPS-1:0];
            r_ovf <= (i_num >> STEPS) >= NUM_W'(i_den);
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_trial - {1'b0, r_den}) : n_trial;
            r_low <= {r_low[STEPS-2:0], 1'b0};
            r_quo <= {r_quo[STEPS-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = (r_ovf || r_quo[STEPS-1]) ? '1 : r_quo[QUO_W-1:0];

endmodule

@@ rtl/wzl_isqrt.sv @@
// Integer square root of a 32-bit word, one result bit per cycle.
`timescale 1ns / 1ps

module wzl_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wzl_pkg::QUO_W-1:0]    i_x,
    output logic                         o_done,
    output logic [wzl_pkg::ROOT_W-1:0]   o_root
);
    import wzl_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [QUO_W-1:0]    r_x;
    logic [ROOT_W-1:0]   r_res;
    logic [ROOT_W-1:0]   r_bit;
    logic [ROOT_W-1:0]   n_cand;
    logic [QUO_W-1:0]    n_cand_sq;

    // Try the next bit of the root.
    assign n_cand    = r_res | r_bit;
    assign n_cand_sq = n_cand * n_cand;

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Root and bit mask.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= {1'b1, {(ROOT_W-1){1'b0}}};
        end else if (r_busy) begin
            if (n_cand_sq <= r_x) begin
                r_res <= n_cand;
            end
            r_bit <= r_bit >> 1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res;

endmodule

@@ rtl/wzl_dp.sv @@
// Datapath: price ring, window sums, label, deviation, divider and square root.
`timescale 1ns / 1ps

module wzl_dp #(
    parameter int WINDOW  = 64,
    parameter int HORIZON = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wzl_pkg::t_cmd                 i_cmd,
    output wzl_pkg::t_stat                o_stat,
    input  logic [wzl_pkg::PRICE_W-1:0]   i_close_price,
    input  logic                          i_cfg_we,
    input  logic [wzl_pkg::THR_W-1:0]     i_cfg_wdata,
    output logic [wzl_pkg::NORM_W-1:0]    o_norm_value,
    output logic [wzl_pkg::POS_W-1:0]     o_position,
    output logic                          o_up_label,
    output logic                          o_last
);
    import wzl_pkg::*;

    localparam int RING = WINDOW + HORIZON + 1;
    localparam int AW   = $clog2(RING);
    localparam int FW   = $clog2(RING + 1);
    localparam int CW   = $clog2(WINDOW);
    localparam int KW   = (CW < 1) ? 1 : CW;
    localparam int SW   = PRICE_W + CW;
    localparam int QW   = 2 * PRICE_W + CW;
    localparam int DW   = 2 * SW;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] ptr);
        ring_next = (ptr == AW'(RING - 1)) ? '0 : ptr + 1'b1;
    endfunction

    logic [PRICE_W-1:0]   r_ring [RING];
    logic [PRICE_W-1:0]   r_rdata;
    logic [AW-1:0]        r_wp;
    logic [AW-1:0]        r_rp;
    logic [AW-1:0]        r_base;
    logic [FW-1:0]        r_fill;
    logic [THR_W-1:0]     r_thr;
    logic [PRICE_W-1:0]   r_fut;
    logic [KW-1:0]        r_k;
    logic [SW-1:0]        r_sum;
    logic [QW-1:0]        r_sqsum;
    logic [SW-1:0]        r_sq_x;
    logic [2*PRICE_W-1:0] r_pll;
    logic [PRICE_W+CW-1:0] r_plh;
    logic [2*CW-1:0]      r_phh;
    logic [DW-1:0]        r_sq;
    logic [DW-1:0]        r_den;
    logic                 r_flat;
    logic                 r_label;
    logic                 r_neg;
    logic [NORM_W-1:0]    r_norm;
    logic [POS_W-1:0]     r_pos;
    logic                 r_out_label;
    logic                 r_last;

    logic [DW-1:0]        n_den;
    logic [SW-1:0]        n_a;
    logic [SW-1:0]        n_mag;
    logic                 n_a_lt;
    logic                 n_label;
    logic [QUO_W-1:0]     w_quo;
    logic [ROOT_W-1:0]    w_root;
    logic [ROOT_W:0]      n_q;
    logic [NORM_W-1:0]    n_norm;
    logic                 w_div_done;
    logic                 w_sqrt_done;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // Ring memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_ring[r_wp] <= i_close_price;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_ring[r_rp];
        end
    end

    // Write pointer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cmd.store) begin
            r_wp <= ring_next(r_wp);
            if (r_fill < FW'(RING)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // Read pointer: starts at the oldest window price, rewinds for the second pass.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_rp   <= ring_next(r_wp);
            r_base <= ring_next(r_wp);
            r_fut  <= i_close_price;
        end else if (i_cmd.den) begin
            r_rp <= r_base;
        end else if (i_cmd.rd) begin
            r_rp <= ring_next(r_rp);
        end
    end

    // Position counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store || i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
    end

    // Two-stage squaring pipeline, split at bit 32.
    always_ff @(posedge i_clk) begin
        r_pll <= r_sq_x[PRICE_W-1:0] * r_sq_x[PRICE_W-1:0];
        r_plh <= r_sq_x[PRICE_W-1:0] * r_sq_x[SW-1:PRICE_W];
        r_phh <= r_sq_x[SW-1:PRICE_W] * r_sq_x[SW-1:PRICE_W];
        r_sq  <= DW'(r_pll) + (DW'(r_plh) << (PRICE_W + 1)) + (DW'(r_phh) << (2 * PRICE_W));
    end

    // Variance term W*Q - S*S, label and deviation magnitude.
    assign n_den   = DW'(r_sqsum) * DW'(WINDOW) - r_sq;
    assign n_label = {r_fut, 16'b0} >= (49'(r_rdata) * 49'(17'h10000 + 17'(r_thr)));
    assign n_a     = SW'(r_rdata) * SW'(WINDOW);
    assign n_a_lt  = n_a < r_sum;
    assign n_mag   = n_a_lt ? (r_sum - n_a) : (n_a - r_sum);

    // Window sums and per-sample terms.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_sum   <= '0;
            r_sqsum <= '0;
        end
        if (i_cmd.p1_dat) begin
            r_sum  <= r_sum + SW'(r_rdata);
            r_sq_x <= SW'(r_rdata);
        end
        if (i_cmd.p1_acc) begin
            r_sqsum <= r_sqsum + QW'(r_sq);
        end
        if (i_cmd.ref_dat) begin
            r_label <= n_label;
            r_sq_x  <= r_sum;
        end
        if (i_cmd.den) begin
            r_den  <= n_den;
            r_flat <= (n_den == '0);
        end
        if (i_cmd.p2_dat) begin
            r_neg  <= n_a_lt;
            r_sq_x <= n_mag;
        end
    end

    // Quotient mag^2 * 2^24 / den, then its square root.
    wzl_div #(
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({r_sq, 24'b0}),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    wzl_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_x     (w_quo),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Round to nearest: q = (root + 1) / 2, then apply sign and saturate.
    assign n_q = ({1'b0, w_root} + 1'b1) >> 1;
    always_comb begin
        if (r_flat) begin
            n_norm = '0;
        end else if (r_neg) begin
            n_norm = NORM_W'(17'h10000 - n_q);
        end else if (n_q > 17'd32767) begin
            n_norm = 16'h7FFF;
        end else begin
            n_norm = n_q[NORM_W-1:0];
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_norm      <= n_norm;
            r_pos       <= POS_W'(r_k);
            r_out_label <= r_label;
            r_last      <= (r_k == KW'(WINDOW - 1));
        end
    end

    assign o_norm_value = r_norm;
    assign o_position   = r_pos;
    assign o_up_label   = r_out_label;
    assign o_last       = r_last;

    assign o_stat.full_next = (r_fill >= FW'(RING - 1));
    assign o_stat.k_last    = (r_k == KW'(WINDOW - 1));
    assign o_stat.flat      = r_flat;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.sqrt_done = w_sqrt_done;

endmodule

@@ rtl/wzl_ctrl.sv @@
// Controller: sequences storing, the two window passes and each output word.
`timescale 1ns / 1ps

module wzl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output wzl_pkg::t_cmd    o_cmd,
    input  wzl_pkg::t_stat   i_stat
);
    import wzl_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_P1_RD     = 5'd1;
    localparam logic [4:0] S_P1_DAT    = 5'd2;
    localparam logic [4:0] S_P1_W1     = 5'd3;
    localparam logic [4:0] S_P1_W2     = 5'd4;
    localparam logic [4:0] S_P1_ACC    = 5'd5;
    localparam logic [4:0] S_REF_RD    = 5'd6;
    localparam logic [4:0] S_REF_DAT   = 5'd7;
    localparam logic [4:0] S_DEN_W1    = 5'd8;
    localparam logic [4:0] S_DEN_W2    = 5'd9;
    localparam logic [4:0] S_DEN       = 5'd10;
    localparam logic [4:0] S_P2_RD     = 5'd11;
    localparam logic [4:0] S_P2_DAT    = 5'd12;
    localparam logic [4:0] S_P2_W1     = 5'd13;
    localparam logic [4:0] S_P2_W2     = 5'd14;
    localparam logic [4:0] S_DIV       = 5'd15;
    localparam logic [4:0] S_DIV_WAIT  = 5'd16;
    localparam logic [4:0] S_SQRT      = 5'd17;
    localparam logic [4:0] S_SQRT_WAIT = 5'd18;
    localparam logic [4:0] S_LOAD      = 5'd19;
    localparam logic [4:0] S_EMIT      = 5'd20;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_stat.full_next) begin
                        n_state = S_P1_RD;
                    end
                end
            end
            S_P1_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_P1_DAT;
            end
            S_P1_DAT: begin
                o_cmd.p1_dat = 1'b1;
                n_state      = S_P1_W1;
            end
            S_P1_W1: begin
                n_state = S_P1_W2;
            end
            S_P1_W2: begin
                n_state = S_P1_ACC;
            end
            S_P1_ACC: begin
                o_cmd.p1_acc = 1'b1;
                if (i_stat.k_last) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_REF_RD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_P1_RD;
                end
            end
            S_REF_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_REF_DAT;
            end
            S_REF_DAT: begin
                o_cmd.ref_dat = 1'b1;
                n_state       = S_DEN_W1;
            end
            S_DEN_W1: begin
                n_state = S_DEN_W2;
            end
            S_DEN_W2: begin
                n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_state   = S_P2_RD;
            end
            S_P2_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_P2_DAT;
            end
            S_P2_DAT: begin
                o_cmd.p2_dat = 1'b1;
                n_state      = i_stat.flat ? S_LOAD : S_P2_W1;
            end
            S_P2_W1: begin
                n_state = S_P2_W2;
            end
            S_P2_W2: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (i_stat.sqrt_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_out = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    if (i_stat.k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_P2_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/wzl_checker.sv @@
// Port-level checks of the labeler and their binding to the top level.
`timescale 1ns / 1ps

module wzl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [wzl_pkg::NORM_W-1:0]    o_norm_value,
    input  logic [wzl_pkg::POS_W-1:0]     o_position,
    input  logic                          o_up_label,
    input  logic                          o_last
);
    import wzl_pkg::*;

    // While a result word is offered, no new price is taken.
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result word is pending");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_norm_value)
            && $stable(o_position) && $stable(o_up_label) && $stable(o_last))
        else $error("stalled result word changed");

    // After the last word of a window the block returns to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after the last word of a window");

    // Inside a window the block keeps the input stalled between words.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_in_stall && !o_out_valid)
        else $error("window released the input before its last word");

endmodule

bind window_zscore_labeler wzl_checker u_wzl_checker (.*);
